### sv/erpm_pkg.sv
// shared constants and types for the encoder rpm estimator
package erpm_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int COUNT_IN_W = 32;
    localparam int RPM_W      = 24;
    localparam int CPR_W      = 24;
    localparam int INTERVAL_W = 24;
    localparam int ALPHA_W    = 16;

    // default design parameters
    localparam int COUNT_BITS_DEF    = 32;
    localparam int RPM_FRAC_BITS_DEF = 8;

    // microseconds per minute and the multiplier steps it needs
    localparam int US_PER_MIN_W = 26;
    localparam logic [US_PER_MIN_W-1:0] US_PER_MIN = US_PER_MIN_W'(60000000);

    // register reset values
    localparam logic [CPR_W-1:0]      CPR_RESET      = CPR_W'(4800);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10000);
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = ALPHA_W'(9830);

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_CPR      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA    = 2'd2;

    // configuration seen by the wheel engines
    typedef struct packed {
        logic [CPR_W-1:0]      cpr;
        logic [INTERVAL_W-1:0] interval;
        logic [ALPHA_W-1:0]    alpha;
    } cfg_t;

    // wheel engine status toward the top level
    typedef struct packed {
        logic             done;
        logic             updated;
        logic [RPM_W-1:0] rpm;
    } wheel_stat_t;

endpackage

### sv/erpm_in_if.sv
// sample channel: timestamp and both encoder counts
interface erpm_in_if;
    import erpm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TIME_W-1:0]     now_us;
    logic [COUNT_IN_W-1:0] right_count;
    logic [COUNT_IN_W-1:0] left_count;

    modport source (output valid, output now_us, output right_count, output left_count,
                    input ready);
    modport sink   (input valid, input now_us, input right_count, input left_count,
                    output ready);
endinterface

### sv/erpm_out_if.sv
// speed channel: filtered speeds and update flags
interface erpm_out_if;
    import erpm_pkg::*;

    logic             valid;
    logic             ready;
    logic [RPM_W-1:0] right_rpm;
    logic [RPM_W-1:0] left_rpm;
    logic             right_updated;
    logic             left_updated;

    modport source (output valid, output right_rpm, output left_rpm,
                    output right_updated, output left_updated, input ready);
    modport sink   (input valid, input right_rpm, input left_rpm,
                    input right_updated, input left_updated, output ready);
endinterface

### sv/erpm_serial_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module erpm_serial_mul #(
    parameter int A_W = 32,
    parameter int B_W = 26,
    parameter int P_W = 58
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] product
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   mcand_reg;
    logic [B_W-1:0]   mplier_reg;
    logic [P_W-1:0]   acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(B_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial product accumulation
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= P_W'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

### sv/erpm_serial_div.sv
// restoring divider, one quotient bit per cycle, quotient saturates at all ones
module erpm_serial_div #(
    parameter int N_W = 66,
    parameter int D_W = 56,
    parameter int Q_W = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [Q_W-1:0] quotient
);
    localparam int HI_W  = N_W - Q_W;
    localparam int CMP_W = (HI_W > D_W) ? HI_W : D_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [D_W-1:0]   dvs_reg;
    logic [D_W-1:0]   rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] dvs_ext;
    logic             overflow;
    logic [D_W:0]     trial;
    logic [D_W:0]     trial_sub;
    logic             fits;

    // quotient too wide when the upper dividend part reaches the divisor
    assign hi_ext   = CMP_W'(dividend[N_W-1:Q_W]);
    assign dvs_ext  = CMP_W'(divisor);
    assign overflow = (hi_ext >= dvs_ext);

    // one restoring step
    assign trial     = {rem_reg, low_reg[Q_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    // step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(Q_W);
                if (overflow)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg  <= divisor;
            rem_reg  <= D_W'(dividend[N_W-1:Q_W]);
            low_reg  <= dividend[Q_W-1:0];
            quot_reg <= overflow ? '1 : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial_sub[D_W-1:0] : trial[D_W-1:0];
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule

### sv/erpm_wheel.sv
// per-wheel speed engine: due check, rpm divide and moving average
module erpm_wheel #(
    parameter int COUNT_BITS    = erpm_pkg::COUNT_BITS_DEF,
    parameter int RPM_FRAC_BITS = erpm_pkg::RPM_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [erpm_pkg::TIME_W-1:0]   now,
    input  logic [COUNT_BITS-1:0]         count,
    input  erpm_pkg::cfg_t                cfg,
    output erpm_pkg::wheel_stat_t         stat
);
    import erpm_pkg::*;

    localparam int NUM_W = COUNT_BITS + US_PER_MIN_W;
    localparam int DEN_W = TIME_W + CPR_W;
    localparam int DVD_W = NUM_W + RPM_FRAC_BITS;
    localparam int MIX_W = RPM_W + 1 + ALPHA_W;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_MIX} state_t;

    state_t                state_reg;
    logic [TIME_W-1:0]     prev_time_reg;
    logic [COUNT_BITS-1:0] last_count_reg;
    logic [RPM_W-1:0]      avg_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] delta_reg;
    logic [TIME_W-1:0]     dt_reg;
    logic [RPM_W-1:0]      raw_reg;
    logic                  updated_reg;
    logic                  done_reg;
    logic                  mul_start_reg;
    logic                  div_start_reg;
    logic                  mix_start_reg;

    logic [TIME_W-1:0]     dt;
    logic                  due;
    logic [COUNT_BITS-1:0] delta;
    logic                  num_done;
    logic                  den_done;
    logic                  div_done;
    logic                  mix_done;
    logic [NUM_W-1:0]      num_prod;
    logic [DEN_W-1:0]      den_prod;
    logic [RPM_W-1:0]      div_quot;
    logic [DVD_W-1:0]      dividend;
    logic [RPM_W:0]        diff;
    logic [MIX_W-1:0]      mix_a;
    logic [MIX_W-1:0]      mix_prod;
    logic [MIX_W-1:0]      mix_sum;

    // elapsed time and count difference, both modular
    assign dt    = now - prev_time_reg;
    assign due   = (dt >= TIME_W'(cfg.interval));
    assign delta = count - last_count_reg;

    // delta * us per minute
    erpm_serial_mul #(
        .A_W (COUNT_BITS),
        .B_W (US_PER_MIN_W),
        .P_W (NUM_W)
    ) u_num_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (delta_reg),
        .b       (US_PER_MIN),
        .done    (num_done),
        .product (num_prod)
    );

    // elapsed time * counts per rev, stepped in lockstep with the numerator
    erpm_serial_mul #(
        .A_W (TIME_W),
        .B_W (US_PER_MIN_W),
        .P_W (DEN_W)
    ) u_den_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (dt_reg),
        .b       (US_PER_MIN_W'(cfg.cpr)),
        .done    (den_done),
        .product (den_prod)
    );

    // fixed-point rpm quotient
    assign dividend = DVD_W'(num_prod) << RPM_FRAC_BITS;

    erpm_serial_div #(
        .N_W (DVD_W),
        .D_W (DEN_W),
        .Q_W (RPM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dividend),
        .divisor  (den_prod),
        .done     (div_done),
        .quotient (div_quot)
    );

    // avg + alpha * (raw - avg), signed difference sign-extended
    assign diff  = {1'b0, raw_reg} - {1'b0, avg_reg};
    assign mix_a = {{ALPHA_W{diff[RPM_W]}}, diff};

    erpm_serial_mul #(
        .A_W (MIX_W),
        .B_W (ALPHA_W),
        .P_W (MIX_W)
    ) u_mix_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mix_start_reg),
        .a       (mix_a),
        .b       (cfg.alpha),
        .done    (mix_done),
        .product (mix_prod)
    );

    assign mix_sum = MIX_W'({avg_reg, ALPHA_W'(0)}) + mix_prod;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_time_reg  <= '0;
            last_count_reg <= '0;
            avg_reg        <= '0;
            now_reg        <= '0;
            count_reg      <= '0;
            delta_reg      <= '0;
            dt_reg         <= '0;
            raw_reg        <= '0;
            updated_reg    <= 1'b0;
            done_reg       <= 1'b0;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            mix_start_reg  <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            mix_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (due)
                        begin
                            now_reg       <= now;
                            count_reg     <= count;
                            delta_reg     <= delta;
                            dt_reg        <= dt;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL;
                        end
                        else
                        begin
                            updated_reg <= 1'b0;
                            done_reg    <= 1'b1;
                        end
                    end
                end
                S_MUL:
                begin
                    if (num_done && den_done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        // no movement means zero speed, even with a zero divisor
                        raw_reg       <= (delta_reg == '0) ? '0 : div_quot;
                        mix_start_reg <= 1'b1;
                        state_reg     <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    if (mix_done)
                    begin
                        avg_reg        <= mix_sum[RPM_W+ALPHA_W-1:ALPHA_W];
                        prev_time_reg  <= now_reg;
                        last_count_reg <= count_reg;
                        updated_reg    <= 1'b1;
                        done_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.done    = done_reg;
    assign stat.updated = updated_reg;
    assign stat.rpm     = avg_reg;
endmodule

### sv/encoder_rpm_estimator_unit.sv
// top level: configuration registers, two wheel engines and the result register
// a due wheel runs 26 multiply, 24 divide and 16 average steps; a saturating divide skips
//   its steps, and a wheel that is not due reports done without any
// one sample at a time: a new sample waits until both wheels are done and the result has
//   moved into the output register; the next sample is taken while a result waits there
// reset: asynchronous active low; registers return to their defaults, wheel state to zero
module encoder_rpm_estimator_unit #(
    parameter int COUNT_BITS    = erpm_pkg::COUNT_BITS_DEF,
    parameter int RPM_FRAC_BITS = erpm_pkg::RPM_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [erpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [erpm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [erpm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    erpm_in_if.sink                         sample_in,
    erpm_out_if.source                      speed_out
);
    import erpm_pkg::*;

    cfg_t                 cfg_reg;
    logic                 busy_reg;
    logic                 rdone_reg;
    logic                 ldone_reg;
    logic                 out_valid_reg;
    logic [RPM_W-1:0]     right_rpm_reg;
    logic [RPM_W-1:0]     left_rpm_reg;
    logic                 right_upd_reg;
    logic                 left_upd_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 accept;
    logic                 transfer;
    wheel_stat_t          right_stat;
    wheel_stat_t          left_stat;

    // register write and read decode
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cpr      <= CPR_RESET;
            cfg_reg.interval <= INTERVAL_RESET;
            cfg_reg.alpha    <= ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_CPR:      cfg_reg.cpr      <= pwdata[CPR_W-1:0];
                REG_INTERVAL: cfg_reg.interval <= pwdata[INTERVAL_W-1:0];
                REG_ALPHA:    cfg_reg.alpha    <= pwdata[ALPHA_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CPR:      prdata = APB_DATA_W'(cfg_reg.cpr);
            REG_INTERVAL: prdata = APB_DATA_W'(cfg_reg.interval);
            REG_ALPHA:    prdata = APB_DATA_W'(cfg_reg.alpha);
            default:      prdata = '0;
        endcase
    end

    // input transaction starts both wheels
    assign sample_in.ready = !busy_reg;
    assign accept          = sample_in.valid && !busy_reg;

    erpm_wheel #(
        .COUNT_BITS    (COUNT_BITS),
        .RPM_FRAC_BITS (RPM_FRAC_BITS)
    ) u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .now   (sample_in.now_us),
        .count (sample_in.right_count[COUNT_BITS-1:0]),
        .cfg   (cfg_reg),
        .stat  (right_stat)
    );

    erpm_wheel #(
        .COUNT_BITS    (COUNT_BITS),
        .RPM_FRAC_BITS (RPM_FRAC_BITS)
    ) u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .now   (sample_in.now_us),
        .count (sample_in.left_count[COUNT_BITS-1:0]),
        .cfg   (cfg_reg),
        .stat  (left_stat)
    );

    // move the finished result into the output register once it is free
    assign transfer = busy_reg && rdone_reg && ldone_reg && (!out_valid_reg || speed_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rdone_reg     <= 1'b0;
            ldone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            if (right_stat.done)
            begin
                rdone_reg <= 1'b1;
            end
            if (left_stat.done)
            begin
                ldone_reg <= 1'b1;
            end
            if (transfer)
            begin
                busy_reg      <= 1'b0;
                rdone_reg     <= 1'b0;
                ldone_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (speed_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (transfer)
        begin
            right_rpm_reg <= right_stat.rpm;
            left_rpm_reg  <= left_stat.rpm;
            right_upd_reg <= right_stat.updated;
            left_upd_reg  <= left_stat.updated;
        end
    end

    assign speed_out.valid         = out_valid_reg;
    assign speed_out.right_rpm     = right_rpm_reg;
    assign speed_out.left_rpm      = left_rpm_reg;
    assign speed_out.right_updated = right_upd_reg;
    assign speed_out.left_updated  = left_upd_reg;
endmodule

### bench/encoder_rpm_estimator_unit_test.sv
// testbench for encoder_rpm_estimator_unit: random sample traffic checked against a speed predictor
`timescale 1ns / 1ps

module encoder_rpm_estimator_unit_test;
    import erpm_pkg::*;

    localparam logic [RPM_W-1:0] RPM_LIMIT = {RPM_W{1'b1}};
    localparam int FRAC_BITS = RPM_FRAC_BITS_DEF;
    localparam int TAIL_CYCLES = 100;
    localparam int LONG_STALL_CYCLES = 300;

    typedef struct packed {
        logic [TIME_W-1:0]     now_us;
        logic [COUNT_IN_W-1:0] right_count;
        logic [COUNT_IN_W-1:0] left_count;
    } enc_sample_t;

    typedef struct packed {
        logic [RPM_W-1:0] right_rpm;
        logic [RPM_W-1:0] left_rpm;
        logic             right_updated;
        logic             left_updated;
    } speed_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    erpm_in_if  sample_in ();
    erpm_out_if speed_out ();

    encoder_rpm_estimator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sample_in (sample_in),
        .speed_out (speed_out)
    );

    // clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predicted configuration and wheel state
    logic [CPR_W-1:0]      cfg_cpr;
    logic [INTERVAL_W-1:0] cfg_interval;
    logic [ALPHA_W-1:0]    cfg_alpha;
    logic [TIME_W-1:0]     right_time_q, left_time_q;
    logic [COUNT_IN_W-1:0] right_count_q, left_count_q;
    logic [RPM_W-1:0]      right_avg_q, left_avg_q;

    enc_sample_t sample_queue [$];
    speed_t      speed_expect [$];

    int mismatches = 0;
    int samples_offered = 0;
    int samples_taken = 0;
    int speeds_seen = 0;
    int right_updates = 0;
    int left_updates = 0;
    int reg_writes = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit no_idle = 1'b0;
    bit long_stall_req = 1'b0;

    // traffic generator state
    logic [TIME_W-1:0]     gen_time = '0;
    logic [COUNT_IN_W-1:0] gen_right = '0;
    logic [COUNT_IN_W-1:0] gen_left = '0;

    // floor(delta * 60e6 * 2^frac / (cpr * dt)), saturated
    function automatic logic [RPM_W-1:0] raw_rpm(logic [63:0] delta, logic [63:0] dt);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        num = delta * 64'(US_PER_MIN);
        den = 64'(cfg_cpr) * dt;
        if (delta == 0)
            return '0;
        if (den == 0)
            return RPM_LIMIT;
        quo = num / den;
        rem = num % den;
        if (quo > 64'(RPM_LIMIT >> FRAC_BITS))
            return RPM_LIMIT;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return (quo > 64'(RPM_LIMIT)) ? RPM_LIMIT : quo[RPM_W-1:0];
    endfunction

    // one wheel: update the average once the sample interval has elapsed
    function automatic bit advance_wheel(input logic [TIME_W-1:0] now,
                                         input logic [COUNT_IN_W-1:0] count,
                                         inout logic [TIME_W-1:0] prev_time,
                                         inout logic [COUNT_IN_W-1:0] last_count,
                                         inout logic [RPM_W-1:0] avg);
        logic [TIME_W-1:0]     dt;
        logic [COUNT_IN_W-1:0] delta;
        logic [RPM_W-1:0]      raw;
        logic [63:0]           mix;
        dt = now - prev_time;
        if (dt < TIME_W'(cfg_interval))
            return 1'b0;
        delta = count - last_count;
        raw = raw_rpm(64'(delta), 64'(dt));
        mix = 64'(cfg_alpha) * 64'(raw) + (64'd65536 - 64'(cfg_alpha)) * 64'(avg);
        avg = mix[16 +: RPM_W];
        last_count = count;
        prev_time = now;
        return 1'b1;
    endfunction

    function automatic speed_t predict_speeds(enc_sample_t s);
        speed_t res;
        res.right_updated = advance_wheel(s.now_us, s.right_count,
                                          right_time_q, right_count_q, right_avg_q);
        res.left_updated = advance_wheel(s.now_us, s.left_count,
                                         left_time_q, left_count_q, left_avg_q);
        res.right_rpm = right_avg_q;
        res.left_rpm = left_avg_q;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_in.valid = 1'b0;
        else if (sample_in.valid && samples_taken != samples_offered)
            sample_in.valid = 1'b1;
        else if (send_gap > 0)
        begin
            sample_in.valid = 1'b0;
            send_gap--;
        end
        else if (sample_queue.size() == 0)
            sample_in.valid = 1'b0;
        else if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            sample_in.valid = 1'b0;
            send_gap = $urandom_range(0, 3);
        end
        else
        begin
            enc_sample_t s;
            s = sample_queue.pop_front();
            sample_in.now_us = s.now_us;
            sample_in.right_count = s.right_count;
            sample_in.left_count = s.left_count;
            sample_in.valid = 1'b1;
            samples_offered++;
        end
    end

    // speed receiver, with short bursts and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            speed_out.ready = 1'b0;
        else if (recv_stall > 0)
        begin
            speed_out.ready = 1'b0;
            recv_stall--;
        end
        else if (long_stall_req)
        begin
            speed_out.ready = 1'b0;
            recv_stall = LONG_STALL_CYCLES - 1;
            long_stall_req = 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            speed_out.ready = 1'b0;
            recv_stall = $urandom_range(0, 3);
        end
        else
            speed_out.ready = 1'b1;
    end

    // monitor: check speed transactions, predict on sample transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (speed_out.valid && speed_out.ready)
            begin
                speed_t want;
                speeds_seen++;
                if (speed_out.right_updated)
                    right_updates++;
                if (speed_out.left_updated)
                    left_updates++;
                if (speed_expect.size() == 0)
                begin
                    $display("%0t: unexpected speed transaction, expected none, actual %0h %0h",
                             $time, speed_out.right_rpm, speed_out.left_rpm);
                    mismatches++;
                end
                else
                begin
                    want = speed_expect.pop_front();
                    check_field("right_rpm", 32'(want.right_rpm), 32'(speed_out.right_rpm));
                    check_field("left_rpm", 32'(want.left_rpm), 32'(speed_out.left_rpm));
                    check_field("right_updated", 32'(want.right_updated),
                                32'(speed_out.right_updated));
                    check_field("left_updated", 32'(want.left_updated),
                                32'(speed_out.left_updated));
                end
            end
            if (sample_in.valid && sample_in.ready)
            begin
                enc_sample_t s;
                s.now_us = sample_in.now_us;
                s.right_count = sample_in.right_count;
                s.left_count = sample_in.left_count;
                speed_expect.push_back(predict_speeds(s));
                samples_taken++;
            end
        end
    end

    // register write with readback over the apb port
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_CPR:      stored = 32'(value[CPR_W-1:0]);
            REG_INTERVAL: stored = 32'(value[INTERVAL_W-1:0]);
            default:      stored = 32'(value[ALPHA_W-1:0]);
        endcase
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        case (idx)
            REG_CPR:      cfg_cpr = stored[CPR_W-1:0];
            REG_INTERVAL: cfg_interval = stored[INTERVAL_W-1:0];
            default:      cfg_alpha = stored[ALPHA_W-1:0];
        endcase
        reg_writes++;
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        check_field("register readback", stored, prdata);
        check_field("pready", 32'd1, 32'(pready));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] cpr, input logic [31:0] interval,
                              input logic [31:0] alpha);
        write_reg(REG_CPR, cpr);
        write_reg(REG_INTERVAL, interval);
        write_reg(REG_ALPHA, alpha);
    endtask

    task automatic push_sample(input logic [31:0] now, input logic [31:0] rc,
                               input logic [31:0] lc);
        enc_sample_t s;
        s.now_us = now;
        s.right_count = rc;
        s.left_count = lc;
        sample_queue.push_back(s);
    endtask

    // wait until the block is idle and every speed transaction has arrived
    task automatic wait_drain();
        while (sample_queue.size() != 0 || sample_in.valid || speed_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_delta();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 16);
            1:       return $urandom_range(0, 2000);
            2:       return $urandom_range(0, 200000);
            default: return $urandom;
        endcase
    endfunction

    // mostly steady motion near the sample interval, some noise and broken steps
    task automatic queue_traffic(input int count);
        int kind;
        logic [31:0] step;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 2)
                push_sample($urandom, $urandom, $urandom);
            else
            begin
                if (cfg_interval == 0)
                    step = $urandom_range(0, 40);
                else
                    step = $urandom_range(32'(cfg_interval) / 2, 32'(cfg_interval) * 2);
                if (kind == 2)
                    gen_time = gen_time - $urandom_range(1, 1000);
                else
                    gen_time = gen_time + step;
                if (kind == 3)
                begin
                    gen_right = gen_right - $urandom_range(1, 5000);
                    gen_left = gen_left - $urandom_range(1, 5000);
                end
                else
                begin
                    gen_right = gen_right + random_delta();
                    gen_left = gen_left + random_delta();
                end
                push_sample(gen_time, gen_right, gen_left);
            end
        end
    endtask

    // run limit
    initial
    begin
        #20_000_000;
        $display("encoder_rpm_estimator_unit test failed");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_in.valid = 1'b0;
        sample_in.now_us = '0;
        sample_in.right_count = '0;
        sample_in.left_count = '0;
        speed_out.ready = 1'b0;
        cfg_cpr = CPR_RESET;
        cfg_interval = INTERVAL_RESET;
        cfg_alpha = ALPHA_RESET;
        right_time_q = '0;
        left_time_q = '0;
        right_count_q = '0;
        left_count_q = '0;
        right_avg_q = '0;
        left_avg_q = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(posedge clk);

        // reset defaults: not yet due, due, zero delta, saturation, count and time wrap
        push_sample(32'd0, 32'd0, 32'd0);
        push_sample(32'd9999, 32'd100, 32'd100);
        push_sample(32'd10000, 32'd4800, 32'd2400);
        push_sample(32'd20000, 32'd4800, 32'd2400);
        push_sample(32'd30000, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
        push_sample(32'd40000, 32'h0000_0010, 32'h0000_0008);
        push_sample(32'hFFFF_F000, 32'h0000_0100, 32'h0000_0100);
        push_sample(32'h0000_1000, 32'h0000_0200, 32'h0000_0180);
        push_sample(32'h0000_2000, 32'h0000_0300, 32'h0000_0200);
        push_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        wait_drain();

        // zero interval, cpr of one, full weight: zero elapsed time cases
        set_config(32'd1, 32'd0, 32'd65535);
        push_sample(32'd5000, 32'd10, 32'd20);
        push_sample(32'd5000, 32'd10, 32'd30);
        push_sample(32'd5001, 32'd11, 32'd31);
        gen_time = 32'd5001;
        queue_traffic(200);
        wait_drain();

        // largest divisor and interval, zero weight
        set_config(32'd16777215, 32'd16777215, 32'd0);
        queue_traffic(150);
        wait_drain();

        // zero divisor
        set_config(32'd0, 32'd1, 32'd32768);
        queue_traffic(30);
        wait_drain();

        // random settings; one phase with a long receiver hold-off, one with a mid drain
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                set_config($urandom_range(1, 16777215), $urandom_range(200, 30000), $urandom);
            else
                set_config($urandom_range(50, 20000), $urandom_range(200, 30000), $urandom);
            queue_traffic(125);
            if (phase == 1)
                long_stall_req = 1'b1;
            if (phase == 2)
                wait_drain();
            queue_traffic(125);
            wait_drain();
        end

        // final stretch without idling on either side
        set_config(32'd4800, 32'd10000, 32'd9830);
        no_idle = 1'b1;
        queue_traffic(200);
        wait_drain();

        $display("covered %0d samples and %0d speed transactions, %0d right and %0d left updates",
                 samples_taken, speeds_seen, right_updates, left_updates);
        $display("over %0d register writes, including zero interval and divisor extremes",
                 reg_writes);
        if (mismatches == 0)
            $display("encoder_rpm_estimator_unit test passed");
        else
            $display("encoder_rpm_estimator_unit test failed");
        $finish;
    end

endmodule

### files.f
sv/erpm_pkg.sv
sv/erpm_in_if.sv
sv/erpm_out_if.sv
sv/erpm_serial_mul.sv
sv/erpm_serial_div.sv
sv/erpm_wheel.sv
sv/encoder_rpm_estimator_unit.sv
bench/encoder_rpm_estimator_unit_test.sv
